### design/debounced_power_toggle_with_fault_macros.svh
// Assertion helpers for the top-level design file.
`ifndef DEBOUNCED_POWER_TOGGLE_WITH_FAULT_MACROS_SVH
`define DEBOUNCED_POWER_TOGGLE_WITH_FAULT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DPTF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("power controller check failed");

// Next-cycle implication, checked outside reset
`define DPTF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("power controller check failed");

`endif

### design/dptf_pkg.sv
package dptf_pkg;

    // Power modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_ERROR = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    // Item kinds
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_ADC  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [1:0] CFG_VDD_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_SETTLE_SAMPLES = 2'd2;

    // Configuration reset values
    localparam logic [3:0]  RST_DEBOUNCE_TICKS = 4'd5;
    localparam logic [11:0] RST_VDD_THRESHOLD  = 12'd200;
    localparam logic [3:0]  RST_SETTLE_SAMPLES = 4'd5;

    typedef struct packed {
        logic [3:0]  debounce_ticks;
        logic [11:0] vdd_threshold;
        logic [3:0]  settle_samples;
    } t_cfg;

    typedef struct packed {
        logic        action;
        logic        button_pressed;
        logic [11:0] vdd_sample;
    } t_item;

    // Packed so that power_state sits in the lowest bits
    typedef struct packed {
        logic       start_conversion;
        logic       status_led;
        logic       discharge_active;
        logic       power_enable;
        logic [1:0] power_state;
    } t_result;

endpackage

### design/dptf_cfg_regs.sv
module dptf_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [11:0]       i_cfg_data,
    output dptf_pkg::t_cfg    o_cfg
);
    import dptf_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= RST_DEBOUNCE_TICKS;
            r_cfg.vdd_threshold  <= RST_VDD_THRESHOLD;
            r_cfg.settle_samples <= RST_SETTLE_SAMPLES;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= i_cfg_data[3:0];
                CFG_VDD_THRESHOLD:  r_cfg.vdd_threshold  <= i_cfg_data;
                CFG_SETTLE_SAMPLES: r_cfg.settle_samples <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/dptf_core.sv
module dptf_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  dptf_pkg::t_item   i_item,
    input  dptf_pkg::t_cfg    i_cfg,
    output dptf_pkg::t_result o_result
);
    import dptf_pkg::*;

    logic [1:0] r_mode,          n_mode;
    logic       r_last_button,   n_last_button;
    logic [4:0] r_stable_count,  n_stable_count;
    logic [3:0] r_settle_count,  n_settle_count;
    logic       r_enable,        n_enable;
    logic       r_discharge,     n_discharge;
    logic       r_led,           n_led;

    logic [4:0] w_limit;
    logic       w_present;

    assign w_limit   = {1'b0, i_cfg.debounce_ticks};
    assign w_present = i_item.vdd_sample > i_cfg.vdd_threshold;

    // Next state for one transaction
    always_comb begin
        n_mode         = r_mode;
        n_last_button  = r_last_button;
        n_stable_count = r_stable_count;
        n_settle_count = r_settle_count;
        n_enable       = r_enable;
        n_discharge    = r_discharge;
        n_led          = r_led;
        if (i_item.action == ACT_ADC) begin
            // Fault check once settling is over
            if (r_mode == MODE_ON && r_settle_count == 4'd0 && !w_present) begin
                n_mode   = MODE_ERROR;
                n_enable = 1'b0;
            end
            n_led = w_present;
            if (r_settle_count != 4'd0) begin
                n_settle_count = r_settle_count - 4'd1;
            end
        end else if (i_item.button_pressed != r_last_button) begin
            // Level change restarts the debounce
            n_stable_count = 5'd0;
            n_last_button  = i_item.button_pressed;
        end else begin
            if (r_stable_count < w_limit + 5'd1) begin
                n_stable_count = r_stable_count + 5'd1;
            end
            // Toggle on a stable press
            if (n_stable_count == w_limit && i_item.button_pressed) begin
                n_settle_count = i_cfg.settle_samples;
                if (r_mode == MODE_ON) begin
                    n_mode      = MODE_OFF;
                    n_enable    = 1'b0;
                    n_discharge = 1'b1;
                end else begin
                    n_mode      = MODE_ON;
                    n_enable    = 1'b1;
                    n_discharge = 1'b0;
                end
            end
        end
    end

    // Advance state on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_OFF;
            r_last_button  <= 1'b0;
            r_stable_count <= 5'd0;
            r_settle_count <= 4'd0;
            r_enable       <= 1'b0;
            r_discharge    <= 1'b0;
            r_led          <= 1'b0;
        end else if (i_fire) begin
            r_mode         <= n_mode;
            r_last_button  <= n_last_button;
            r_stable_count <= n_stable_count;
            r_settle_count <= n_settle_count;
            r_enable       <= n_enable;
            r_discharge    <= n_discharge;
            r_led          <= n_led;
        end
    end

    // Result shows the state after the item
    always_comb begin
        o_result.power_state      = n_mode;
        o_result.power_enable     = n_enable;
        o_result.discharge_active = n_discharge;
        o_result.status_led       = n_led;
        o_result.start_conversion = (i_item.action == ACT_TICK);
    end

endmodule

### design/debounced_power_toggle_with_fault.sv
// Path: an accepted input transaction is held in the input register, then its result in
// the result register, which it leaves when m_axis_tready is high.
// Throughput: one item per cycle while m_axis_tready is high; the power state update
// is one pass of logic between the input register and the result register.
// Reset (i_rst_n low, synchronous): power off, counters and LED cleared,
// configuration back to debounce 5, threshold 200, settle 5; both channels empty.
module debounced_power_toggle_with_fault (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // button_pressed[0], vdd_sample[12:1], zero fill
    input  logic        s_axis_tuser,  // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // power_state[1:0], power_enable[2],
                                       // discharge_active[3], status_led[4],
                                       // start_conversion[5], zero fill
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_data
);
    import dptf_pkg::*;
    `include "debounced_power_toggle_with_fault_macros.svh"

    t_cfg    w_cfg;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result w_result;
    t_result r_out_result;
    logic    r_out_valid;
    logic    w_out_ready;
    logic    w_fire;

    dptf_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Handshake: the result register frees up as its transaction leaves
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_ready;
    assign s_axis_tready = !r_in_valid || w_out_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.action         <= s_axis_tuser;
            r_in_item.button_pressed <= s_axis_tdata[0];
            r_in_item.vdd_sample     <= s_axis_tdata[12:1];
        end
    end

    dptf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_result};

    // Checks
    `DPTF_ASSERT_NOW(a_no_rsvd_mode, m_axis_tvalid, m_axis_tdata[1:0] != MODE_RSVD)
    `DPTF_ASSERT_NOW(a_enable_only_on, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1:0] == MODE_ON)
    `DPTF_ASSERT_NEXT(a_fire_gives_result, w_fire, m_axis_tvalid)

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import dptf_pkg::*;

    // Directed stimulus row: either a register write or one input transaction
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [11:0] reg_val;
        t_item       item;
        bit          typed;
        t_result     want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // button_pressed[0], vdd_sample[12:1], zero fill
    logic        s_axis_tuser = ACT_TICK;  // action[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // power_state[1:0], power_enable[2],
                                      // discharge_active[3], status_led[4],
                                      // start_conversion[5], zero fill
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = CFG_DEBOUNCE_TICKS;
    logic [11:0] i_cfg_data = '0;

    // Mirror of the controller state and its registers
    t_cfg       ctl_cfg;
    logic [1:0] ctl_mode;
    logic       ctl_last_btn;
    logic [4:0] ctl_stable;
    logic [3:0] ctl_settle;
    logic       ctl_en;
    logic       ctl_dis;
    logic       ctl_led;

    t_result    expected_outputs[$];
    t_stim_row  bringup_rows[$];
    int         mismatch_count = 0;

    // Sender burst and receiver stall control
    bit         tx_steady = 1'b0;
    int         burst_left = 0;
    bit         rx_stall_on = 1'b1;
    logic [15:0] rx_pat = '1;
    logic [3:0] rx_pos = '0;

    debounced_power_toggle_with_fault u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("debounced_power_toggle_with_fault verification failed");
        $finish;
    end

    // Advance the controller mirror by one item and return the outputs it shows
    function automatic t_result apply_to_power_model(input t_item it);
        t_result r;
        logic    present;
        if (it.action == ACT_TICK) begin
            if (it.button_pressed != ctl_last_btn) begin
                ctl_stable   = '0;
                ctl_last_btn = it.button_pressed;
            end else begin
                // Saturate one past the debounce count
                if (ctl_stable < {1'b0, ctl_cfg.debounce_ticks} + 5'd1)
                    ctl_stable = ctl_stable + 5'd1;
                if (ctl_stable == {1'b0, ctl_cfg.debounce_ticks} && it.button_pressed) begin
                    ctl_settle = ctl_cfg.settle_samples;
                    if (ctl_mode == MODE_ON) begin
                        ctl_mode = MODE_OFF;
                        ctl_en   = 1'b0;
                        ctl_dis  = 1'b1;
                    end else begin
                        ctl_mode = MODE_ON;
                        ctl_en   = 1'b1;
                        ctl_dis  = 1'b0;
                    end
                end
            end
        end else begin
            present = it.vdd_sample > ctl_cfg.vdd_threshold;
            // Supply missing after settling: fault and drop the enable
            if (ctl_mode == MODE_ON && ctl_settle == 4'd0 && !present) begin
                ctl_mode = MODE_ERROR;
                ctl_en   = 1'b0;
            end
            ctl_led = present;
            if (ctl_settle != 4'd0)
                ctl_settle = ctl_settle - 4'd1;
        end
        r.power_state      = ctl_mode;
        r.power_enable     = ctl_en;
        r.discharge_active = ctl_dis;
        r.status_led       = ctl_led;
        r.start_conversion = (it.action == ACT_TICK);
        return r;
    endfunction

    function automatic t_result obs(input logic [1:0] st, input logic en, input logic dis,
                                    input logic led, input logic conv);
        return '{start_conversion: conv, status_led: led, discharge_active: dis,
                 power_enable: en, power_state: st};
    endfunction

    function automatic t_item mk_item(input logic act, input logic btn, input logic [11:0] vdd);
        return '{action: act, button_pressed: btn, vdd_sample: vdd};
    endfunction

    function automatic t_stim_row item_row(input logic act, input logic btn,
                                           input logic [11:0] vdd);
        t_stim_row r;
        r = '{default: '0};
        r.item = mk_item(act, btn, vdd);
        return r;
    endfunction

    function automatic t_stim_row checked_row(input logic act, input logic btn,
                                              input logic [11:0] vdd, input t_result want);
        t_stim_row r;
        r = item_row(act, btn, vdd);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [1:0] idx, input logic [11:0] val);
        t_stim_row r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Write one register; the block is idle whenever this is called
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_DEBOUNCE_TICKS: ctl_cfg.debounce_ticks = val[3:0];
            CFG_VDD_THRESHOLD:  ctl_cfg.vdd_threshold  = val;
            CFG_SETTLE_SAMPLES: ctl_cfg.settle_samples = val[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every pending result has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_outputs.size() != 0);
    endtask

    // Offer one transaction, with a random gap between bursts unless tx_steady is set
    task automatic send_item(input t_item it, input bit typed, input t_result want);
        int      gap;
        t_result pred;
        gap = 0;
        if (!tx_steady) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.vdd_sample, it.button_pressed};
        s_axis_tuser  <= it.action;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = apply_to_power_model(it);
        expected_outputs.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // Receiver: stall on a random 16-bit mask, or stay ready
    always @(negedge i_clk) begin
        if (!rx_stall_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (rx_pos == 4'd0) begin
                if ($urandom_range(0, 7) == 0)
                    rx_pat = 16'h0000;
                else
                    rx_pat = 16'($urandom | $urandom);
            end
            m_axis_tready <= rx_pat[rx_pos];
            rx_pos = rx_pos + 4'd1;
        end
    end

    // Compare each result transaction against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[5:0]);
            if (expected_outputs.size() == 0) begin
                flag_mismatch("result with nothing pending, data", 0, int'(m_axis_tdata));
            end else begin
                want = expected_outputs.pop_front();
                if (got.power_state !== want.power_state)
                    flag_mismatch("power_state", int'(want.power_state),
                                  int'(got.power_state));
                if (got.power_enable !== want.power_enable)
                    flag_mismatch("power_enable", int'(want.power_enable),
                                  int'(got.power_enable));
                if (got.discharge_active !== want.discharge_active)
                    flag_mismatch("discharge_active", int'(want.discharge_active),
                                  int'(got.discharge_active));
                if (got.status_led !== want.status_led)
                    flag_mismatch("status_led", int'(want.status_led),
                                  int'(got.status_led));
                if (got.start_conversion !== want.start_conversion)
                    flag_mismatch("start_conversion", int'(want.start_conversion),
                                  int'(got.start_conversion));
            end
        end
    end

    initial begin : stimulus
        int          deb;
        int          thr;
        int          vdd;
        int          run_left;
        logic        drive_btn;
        logic        btn;
        logic        act;
        t_item       it;

        run_left  = 0;
        drive_btn = 1'b0;

        // Mirror starts from the reset state
        ctl_cfg      = '{debounce_ticks: RST_DEBOUNCE_TICKS, vdd_threshold: RST_VDD_THRESHOLD,
                         settle_samples: RST_SETTLE_SAMPLES};
        ctl_mode     = MODE_OFF;
        ctl_last_btn = 1'b0;
        ctl_stable   = '0;
        ctl_settle   = '0;
        ctl_en       = 1'b0;
        ctl_dis      = 1'b0;
        ctl_led      = 1'b0;

        // Bring-up table: thresholds, toggles, faults and a disabled debounce
        bringup_rows.push_back(checked_row(ACT_ADC, 1'b0, 12'd4095,
                                           obs(MODE_OFF, 1'b0, 1'b0, 1'b1, 1'b0)));
        bringup_rows.push_back(checked_row(ACT_ADC, 1'b0, 12'd0,
                                           obs(MODE_OFF, 1'b0, 1'b0, 1'b0, 1'b0)));
        bringup_rows.push_back(item_row(ACT_ADC, 1'b0, 12'd200));   // equal is absent
        bringup_rows.push_back(item_row(ACT_ADC, 1'b0, 12'd201));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b0, 12'd4095)); // sample ignored
        bringup_rows.push_back(cfg_row(CFG_DEBOUNCE_TICKS, 12'd1));
        bringup_rows.push_back(cfg_row(CFG_SETTLE_SAMPLES, 12'd0));
        bringup_rows.push_back(cfg_row(CFG_VDD_THRESHOLD, 12'd4095));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));    // level change
        bringup_rows.push_back(checked_row(ACT_TICK, 1'b1, 12'd0,
                                           obs(MODE_ON, 1'b1, 1'b0, 1'b1, 1'b1)));
        // Nothing exceeds full scale, so this faults; button ignored here
        bringup_rows.push_back(checked_row(ACT_ADC, 1'b1, 12'd4095,
                                           obs(MODE_ERROR, 1'b0, 1'b0, 1'b0, 1'b0)));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));    // saturated
        bringup_rows.push_back(item_row(ACT_TICK, 1'b0, 12'd0));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));    // error back to on
        bringup_rows.push_back(cfg_row(CFG_VDD_THRESHOLD, 12'd0));
        bringup_rows.push_back(item_row(ACT_ADC, 1'b0, 12'd1));
        bringup_rows.push_back(checked_row(ACT_ADC, 1'b0, 12'd0,
                                           obs(MODE_ERROR, 1'b0, 1'b0, 1'b0, 1'b0)));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b0, 12'd0));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));    // on
        bringup_rows.push_back(item_row(ACT_TICK, 1'b0, 12'd0));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));    // off, discharge
        bringup_rows.push_back(cfg_row(CFG_DEBOUNCE_TICKS, 12'd0)); // never toggles
        bringup_rows.push_back(item_row(ACT_TICK, 1'b0, 12'd0));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));
        bringup_rows.push_back(item_row(ACT_TICK, 1'b1, 12'd0));

        // Hold reset low, then release it
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (bringup_rows[i]) begin
            if (bringup_rows[i].is_cfg) begin
                wait_idle();
                write_reg(bringup_rows[i].reg_idx, bringup_rows[i].reg_val);
            end else begin
                send_item(bringup_rows[i].item, bringup_rows[i].typed, bringup_rows[i].want);
            end
        end

        // Random phases: mostly held button runs around the debounce length,
        // ADC samples clustered near the threshold
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            tx_steady   = (phase % 3 == 1);
            rx_stall_on = (phase % 3 != 2);
            case (phase)
                0: begin deb = 1;  thr = 0;    write_reg(CFG_SETTLE_SAMPLES, 12'd0); end
                1: begin deb = 15; thr = 4095; write_reg(CFG_SETTLE_SAMPLES, 12'd15); end
                3: begin
                    deb = $urandom_range(0, 15);
                    thr = $urandom_range(0, 4095);
                    write_reg(CFG_SETTLE_SAMPLES, 12'($urandom_range(0, 15)));
                end
                default: begin
                    deb = $urandom_range(1, 4);
                    thr = $urandom_range(0, 4095);
                    write_reg(CFG_SETTLE_SAMPLES, 12'($urandom_range(0, 15)));
                end
            endcase
            write_reg(CFG_DEBOUNCE_TICKS, 12'(deb));
            write_reg(CFG_VDD_THRESHOLD, 12'(thr));

            for (int n = 0; n < 100; n++) begin
                act = ($urandom_range(0, 99) < 35) ? ACT_ADC : ACT_TICK;
                if (act == ACT_ADC) begin
                    case ($urandom_range(0, 3))
                        0: vdd = $urandom_range(0, 4095);
                        1: vdd = $urandom_range(0, 1) ? 4095 : 0;
                        default: begin
                            vdd = thr + int'($urandom_range(0, 4)) - 2;
                            if (vdd < 0) vdd = 0;
                            if (vdd > 4095) vdd = 4095;
                        end
                    endcase
                    btn = 1'($urandom);
                end else begin
                    if (run_left == 0) begin
                        drive_btn = ~drive_btn;
                        run_left  = $urandom_range(1, deb + 3);
                    end
                    run_left--;
                    btn = ($urandom_range(0, 11) == 0) ? 1'($urandom) : drive_btn;
                    vdd = $urandom_range(0, 4095);
                end
                it = mk_item(act, btn, 12'(vdd));
                send_item(it, 1'b0, '0);
            end
        end

        // Drain, then allow for stray results
        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("debounced_power_toggle_with_fault verification clean");
        else
            $display("debounced_power_toggle_with_fault verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/dptf_pkg.sv
design/dptf_cfg_regs.sv
design/dptf_core.sv
design/debounced_power_toggle_with_fault.sv
tb/tb.sv
